>>> hw/rtl/crfe_pkg.sv
// crfe_pkg: constants, codes and shared types of the reply frame engine
// no dependencies; used by every other file of the block but crfe_if
`default_nettype none

package crfe_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hA1;
  localparam logic [3:0] LEN_MASK     = 4'hF;

  localparam logic OP_START = 1'b0;
  localparam logic OP_RX    = 1'b1;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [1:0] ST_BAD_CODE = 2'd2;
  localparam logic [1:0] ST_BAD_SUM  = 2'd3;

  // result count of a transmit group
  localparam logic [1:0] TX_COUNT = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_CODE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SUM     = 5'b10000
  } phase_t;

  // results caused by one accepted item: none, one, or a three byte transmit group
  typedef struct packed {
    logic       valid;
    logic       tx;
    logic [1:0] kind;
    logic [7:0] value;
    logic [3:0] index;
    logic [1:0] status;
  } group_t;

endpackage

`default_nettype wire

>>> hw/rtl/crfe_if.sv
// crfe_in_if / crfe_out_if: valid-ready channels of the reply frame engine
// no dependencies
`default_nettype none

interface crfe_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] command;
  logic [7:0] reply_code;
  logic       expect_reply;
  logic [7:0] rx_byte;

  modport source (output valid, op, command, reply_code, expect_reply, rx_byte,
                  input ready);
  modport sink   (input valid, op, command, reply_code, expect_reply, rx_byte,
                  output ready);
endinterface

interface crfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [3:0] index;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, value, index, status, last, input ready);
  modport sink   (input valid, kind, value, index, status, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/checksummed_reply_frame_engine.sv
// checksummed_reply_frame_engine: the first result of an input transfer is registered and shows in the cycle after it
// a received byte gives at most one result; a start holds the output for three transfers,
// so the next item waits until the third transmit byte leaves
// the input is taken in the same cycle the last held result transfers
// synchronous active-high rst returns the frame state to idle and empties the result register
// depends on crfe_pkg, crfe_if, crfe_ctrl, crfe_out
`default_nettype none

module checksummed_reply_frame_engine (
  input  wire logic  clk,
  input  wire logic  rst,
  crfe_in_if.sink    req,
  crfe_out_if.source rsp
);

  crfe_pkg::group_t group;
  logic             can_load;
  logic             accept;

  assign req.ready = can_load;
  assign accept    = req.valid && can_load;

  crfe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (req.op),
    .command      (req.command),
    .reply_code   (req.reply_code),
    .expect_reply (req.expect_reply),
    .rx_byte      (req.rx_byte),
    .group        (group)
  );

  crfe_out u_out (
    .clk      (clk),
    .rst      (rst),
    .group    (group),
    .can_load (can_load),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

>>> hw/rtl/crfe_ctrl.sv
// crfe_ctrl: frame state machine, checks reply bytes and builds result groups
// depends on crfe_pkg
`default_nettype none

module crfe_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           op,
  input  wire logic [7:0]     command,
  input  wire logic [7:0]     reply_code,
  input  wire logic           expect_reply,
  input  wire logic [7:0]     rx_byte,
  output crfe_pkg::group_t    group
);

  crfe_pkg::phase_t phase, phase_next;
  logic [7:0] awaited_reply, awaited_reply_next;
  logic [3:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [3:0] payload_position, payload_position_next;

  always_comb begin
    phase_next            = phase;
    awaited_reply_next    = awaited_reply;
    bytes_left_next       = bytes_left;
    running_sum_next      = running_sum;
    payload_position_next = payload_position;
    group                 = '0;
    if (accept) begin
      if (op == crfe_pkg::OP_START) begin
        group.valid = 1'b1;
        group.tx    = 1'b1;
        group.kind  = crfe_pkg::KIND_TX;
        group.value = command;
        if (expect_reply) begin
          phase_next         = crfe_pkg::PH_HEADER;
          awaited_reply_next = reply_code;
        end else begin
          phase_next = crfe_pkg::PH_IDLE;
        end
      end else begin
        case (phase)
          crfe_pkg::PH_HEADER: begin
            if (rx_byte != crfe_pkg::FRAME_HEADER) begin
              group.valid  = 1'b1;
              group.kind   = crfe_pkg::KIND_END;
              group.status = crfe_pkg::ST_BAD_HDR;
              phase_next   = crfe_pkg::PH_IDLE;
            end else begin
              phase_next = crfe_pkg::PH_CODE;
            end
          end
          crfe_pkg::PH_CODE: begin
            if (rx_byte != awaited_reply) begin
              group.valid  = 1'b1;
              group.kind   = crfe_pkg::KIND_END;
              group.status = crfe_pkg::ST_BAD_CODE;
              phase_next   = crfe_pkg::PH_IDLE;
            end else begin
              running_sum_next      = rx_byte;
              bytes_left_next       = rx_byte[3:0] & crfe_pkg::LEN_MASK;
              payload_position_next = '0;
              phase_next = ((rx_byte[3:0] & crfe_pkg::LEN_MASK) != '0) ?
                           crfe_pkg::PH_PAYLOAD : crfe_pkg::PH_SUM;
            end
          end
          crfe_pkg::PH_PAYLOAD: begin
            group.valid           = 1'b1;
            group.kind            = crfe_pkg::KIND_PAYLOAD;
            group.value           = rx_byte;
            group.index           = payload_position;
            running_sum_next      = running_sum + rx_byte;
            payload_position_next = payload_position + 4'd1;
            bytes_left_next       = bytes_left - 4'd1;
            if (bytes_left == 4'd1) begin
              phase_next = crfe_pkg::PH_SUM;
            end
          end
          crfe_pkg::PH_SUM: begin
            group.valid  = 1'b1;
            group.kind   = crfe_pkg::KIND_END;
            group.status = (rx_byte == running_sum) ? crfe_pkg::ST_OK
                                                    : crfe_pkg::ST_BAD_SUM;
            phase_next   = crfe_pkg::PH_IDLE;
          end
          default: begin
            // byte with no reply pending is dropped
            phase_next = crfe_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= crfe_pkg::PH_IDLE;
      awaited_reply    <= '0;
      bytes_left       <= '0;
      running_sum      <= '0;
      payload_position <= '0;
    end else begin
      phase            <= phase_next;
      awaited_reply    <= awaited_reply_next;
      bytes_left       <= bytes_left_next;
      running_sum      <= running_sum_next;
      payload_position <= payload_position_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/crfe_out.sv
// crfe_out: result register, plays a held group out one transfer at a time
// depends on crfe_pkg and crfe_if
`default_nettype none

module crfe_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire crfe_pkg::group_t group,
  output logic                  can_load,
  crfe_out_if.source            rsp
);

  logic       busy;
  logic [1:0] cnt;
  logic       tx;
  logic [1:0] kind;
  logic [7:0] value;
  logic [3:0] index;
  logic [1:0] status;
  logic       fire;

  assign fire     = busy && rsp.ready;
  assign can_load = !busy || (fire && cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (group.valid && can_load) begin
      busy <= 1'b1;
      cnt  <= group.tx ? crfe_pkg::TX_COUNT : 2'd1;
    end else if (fire) begin
      if (cnt == 2'd1) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (group.valid && can_load) begin
      tx     <= group.tx;
      kind   <= group.kind;
      value  <= group.value;
      index  <= group.index;
      status <= group.status;
    end
  end

  assign rsp.valid  = busy;
  assign rsp.kind   = kind;
  // transmit group: header first, then the command twice
  assign rsp.value  = (tx && cnt == crfe_pkg::TX_COUNT) ? crfe_pkg::FRAME_HEADER : value;
  assign rsp.index  = index;
  assign rsp.status = status;
  assign rsp.last   = (cnt == 2'd1);

endmodule

`default_nettype wire

>>> hw/rtl/crfe_checker.sv
// crfe_checker: port level assertions on the reply frame engine, bound to its top level
// depends on crfe_pkg and crfe_if
`default_nettype none

module crfe_checker (
  input wire logic   clk,
  input wire logic   rst,
  crfe_in_if.sink    req,
  crfe_out_if.source rsp
);

  // a start shows its header byte right after the transfer
  a_start_header: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.op == crfe_pkg::OP_START |=>
      rsp.valid && rsp.kind == crfe_pkg::KIND_TX && rsp.value == crfe_pkg::FRAME_HEADER)
    else $error("start not followed by header byte");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind == crfe_pkg::KIND_END || rsp.kind == crfe_pkg::KIND_PAYLOAD) |->
      rsp.last)
    else $error("payload or end result without last");

  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == crfe_pkg::KIND_TX |->
      rsp.status == crfe_pkg::ST_OK && rsp.index == 4'd0)
    else $error("transmit result with status or index set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.value) && $stable(rsp.kind))
    else $error("stalled result changed");

endmodule

bind checksummed_reply_frame_engine crfe_checker u_crfe_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

`default_nettype wire
